// ===== rtl/qvr_pkg.sv =====
// Types and constants shared by the quaternion rotation pipeline.
`default_nettype none

package qvr_pkg;

  // Input component width (vector and Q2.14 quaternion)
  localparam int COMP_W = 16;
  // First-level product q*x or w*x
  localparam int PROD_W = 2 * COMP_W;
  // Inner sum t = v x x + w*x, three products
  localparam int TVAL_W = PROD_W + 1;
  // Outer product q*t and the difference r = v x t
  localparam int RVAL_W = COMP_W + TVAL_W;
  // Fraction bits removed by the final rounding (2^-28 scale times two)
  localparam int FRAC_SHIFT = 27;
  // Sum x*2^27 + r + round bias
  localparam int TOT_W = RVAL_W + 1;
  // Rounded value before clipping
  localparam int RND_W = TOT_W - FRAC_SHIFT;
  // Result component width
  localparam int OUT_W = 18;

  localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] OUT_MIN = -RND_W'(1 << (OUT_W - 1));

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TVAL_W-1:0] tval_t;
  typedef logic signed [RVAL_W-1:0] rval_t;
  typedef logic signed [OUT_W-1:0]  rot_t;

endpackage

`default_nettype wire

// ===== rtl/quaternion_vector_rotate.sv =====
// Top level: rotates one 3-D vector by one Q2.14 quaternion per transaction.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  in_vec_x/y/z, in_quat_w/i/j/k (16-bit signed)
//   out      out_valid/out_stall  out_rot_x/y/z (18-bit signed), out_saturated
//
// One transaction per cycle sustained while out_stall is low; there are five
// register stages (products, t sums, wide products, r difference, round/clip).
// Synchronous active-low reset clears the stage valid bits only.
// Stalls propagate back stage by stage; an empty stage keeps filling, so
// bubbles are squeezed out and nothing is dropped or repeated.
`default_nettype none

module quaternion_vector_rotate (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      in_vec_x,
  input  logic signed [15:0]      in_vec_y,
  input  logic signed [15:0]      in_vec_z,
  input  logic signed [15:0]      in_quat_w,
  input  logic signed [15:0]      in_quat_i,
  input  logic signed [15:0]      in_quat_j,
  input  logic signed [15:0]      in_quat_k,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [17:0]      out_rot_x,
  output logic signed [17:0]      out_rot_y,
  output logic signed [17:0]      out_rot_z,
  output logic                    out_saturated
);
  import qvr_pkg::*;

  comp_t vec_in  [3];
  comp_t quat_in [3];

  logic  in_v_b;
  logic  in_s_b;
  comp_t x_b [3];
  comp_t q_b [3];
  tval_t t_b [3];

  logic  v_d;
  logic  s_d;
  comp_t x_d [3];
  rval_t r_d [3];

  rot_t  rot [3];

  // Gather the input components
  assign vec_in[0]  = in_vec_x;
  assign vec_in[1]  = in_vec_y;
  assign vec_in[2]  = in_vec_z;
  assign quat_in[0] = in_quat_i;
  assign quat_in[1] = in_quat_j;
  assign quat_in[2] = in_quat_k;

  qvr_inner u_inner (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .stall_o (in_stall),
    .x_i     (vec_in),
    .w_i     (in_quat_w),
    .q_i     (quat_in),
    .valid_o (in_v_b),
    .stall_i (in_s_b),
    .x_o     (x_b),
    .q_o     (q_b),
    .t_o     (t_b)
  );

  qvr_outer u_outer (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_v_b),
    .stall_o (in_s_b),
    .x_i     (x_b),
    .q_i     (q_b),
    .t_i     (t_b),
    .valid_o (v_d),
    .stall_i (s_d),
    .x_o     (x_d),
    .r_o     (r_d)
  );

  qvr_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v_d),
    .stall_o (s_d),
    .x_i     (x_d),
    .r_i     (r_d),
    .valid_o (out_valid),
    .stall_i (out_stall),
    .rot_o   (rot),
    .sat_o   (out_saturated)
  );

  assign out_rot_x = rot[0];
  assign out_rot_y = rot[1];
  assign out_rot_z = rot[2];

endmodule

`default_nettype wire

// ===== rtl/qvr_inner.sv =====
// Inner stages: t = v cross x + w*x, products then sums, two register stages.
`default_nettype none

module qvr_inner (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          stall_o,
  input  qvr_pkg::comp_t x_i [3],
  input  qvr_pkg::comp_t w_i,
  input  qvr_pkg::comp_t q_i [3],
  output logic          valid_o,
  input  logic          stall_i,
  output qvr_pkg::comp_t x_o [3],
  output qvr_pkg::comp_t q_o [3],
  output qvr_pkg::tval_t t_o [3]
);
  import qvr_pkg::*;

  // Stage A: the nine products
  prod_t pp_r [3];
  prod_t pm_r [3];
  prod_t pw_r [3];
  comp_t xa_r [3];
  comp_t qa_r [3];
  logic  va_r;

  // Stage B: t
  tval_t t_r  [3];
  comp_t xb_r [3];
  comp_t qb_r [3];
  logic  vb_r;

  logic adv_a;
  logic adv_b;

  // A stage moves when it is empty or the next one moves
  assign adv_b   = !vb_r || !stall_i;
  assign adv_a   = !va_r || adv_b;
  assign stall_o = !adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= valid_i;
      if (adv_b) vb_r <= va_r;
    end
  end

  for (genvar n = 0; n < 3; n++) begin : g_comp
    localparam int N1 = (n + 1) % 3;
    localparam int N2 = (n + 2) % 3;

    // Multiply cross and scalar terms
    always_ff @(posedge clk) begin
      if (adv_a) begin
        pp_r[n] <= q_i[N1] * x_i[N2];
        pm_r[n] <= q_i[N2] * x_i[N1];
        pw_r[n] <= w_i * x_i[n];
        xa_r[n] <= x_i[n];
        qa_r[n] <= q_i[n];
      end
    end

    // Sum into t, units of 2^-14
    always_ff @(posedge clk) begin
      if (adv_b) begin
        t_r[n]  <= TVAL_W'(pp_r[n]) - TVAL_W'(pm_r[n]) + TVAL_W'(pw_r[n]);
        xb_r[n] <= xa_r[n];
        qb_r[n] <= qa_r[n];
      end
    end

    assign t_o[n] = t_r[n];
    assign x_o[n] = xb_r[n];
    assign q_o[n] = qb_r[n];
  end

  assign valid_o = vb_r;

endmodule

`default_nettype wire

// ===== rtl/qvr_outer.sv =====
// Outer stages: r = v cross t, products then difference, two register stages.
`default_nettype none

module qvr_outer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          stall_o,
  input  qvr_pkg::comp_t x_i [3],
  input  qvr_pkg::comp_t q_i [3],
  input  qvr_pkg::tval_t t_i [3],
  output logic          valid_o,
  input  logic          stall_i,
  output qvr_pkg::comp_t x_o [3],
  output qvr_pkg::rval_t r_o [3]
);
  import qvr_pkg::*;

  // Stage C: the six wide products
  rval_t pp_r [3];
  rval_t pm_r [3];
  comp_t xc_r [3];
  logic  vc_r;

  // Stage D: r, units of 2^-28
  rval_t r_r  [3];
  comp_t xd_r [3];
  logic  vd_r;

  logic adv_c;
  logic adv_d;

  assign adv_d   = !vd_r || !stall_i;
  assign adv_c   = !vc_r || adv_d;
  assign stall_o = !adv_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (adv_c) vc_r <= valid_i;
      if (adv_d) vd_r <= vc_r;
    end
  end

  for (genvar n = 0; n < 3; n++) begin : g_comp
    localparam int N1 = (n + 1) % 3;
    localparam int N2 = (n + 2) % 3;

    // Multiply quaternion parts by t
    always_ff @(posedge clk) begin
      if (adv_c) begin
        pp_r[n] <= q_i[N1] * t_i[N2];
        pm_r[n] <= q_i[N2] * t_i[N1];
        xc_r[n] <= x_i[n];
      end
    end

    // Take the difference
    always_ff @(posedge clk) begin
      if (adv_d) begin
        r_r[n]  <= pp_r[n] - pm_r[n];
        xd_r[n] <= xc_r[n];
      end
    end

    assign r_o[n] = r_r[n];
    assign x_o[n] = xd_r[n];
  end

  assign valid_o = vd_r;

endmodule

`default_nettype wire

// ===== rtl/qvr_round.sv =====
// Final stage: add x, round to nearest, clip to the result range, output register.
`default_nettype none

module qvr_round (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          stall_o,
  input  qvr_pkg::comp_t x_i [3],
  input  qvr_pkg::rval_t r_i [3],
  output logic          valid_o,
  input  logic          stall_i,
  output qvr_pkg::rot_t  rot_o [3],
  output logic          sat_o
);
  import qvr_pkg::*;

  rot_t rot_r [3];
  logic sat_r;
  logic ve_r;
  logic adv_e;

  rot_t rot_nxt [3];
  logic [2:0] clip_hit;

  assign adv_e   = !ve_r || !stall_i;
  assign stall_o = !adv_e;

  // Round x + 2r once (ties toward plus infinity), then clip
  for (genvar n = 0; n < 3; n++) begin : g_comp
    logic signed [TOT_W-1:0] total;
    logic signed [RND_W-1:0] rnd;

    always_comb begin
      total = (TOT_W'(x_i[n]) <<< FRAC_SHIFT) + TOT_W'(r_i[n])
            + (TOT_W'(1) <<< (FRAC_SHIFT - 1));
      rnd   = total[TOT_W-1:FRAC_SHIFT];
      if (rnd > OUT_MAX) begin
        rot_nxt[n]  = OUT_MAX[OUT_W-1:0];
        clip_hit[n] = 1'b1;
      end else if (rnd < OUT_MIN) begin
        rot_nxt[n]  = OUT_MIN[OUT_W-1:0];
        clip_hit[n] = 1'b1;
      end else begin
        rot_nxt[n]  = rnd[OUT_W-1:0];
        clip_hit[n] = 1'b0;
      end
    end

    assign rot_o[n] = rot_r[n];
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv_e) begin
      ve_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_e) begin
      rot_r <= rot_nxt;
      sat_r <= |clip_hit;
    end
  end

  assign valid_o = ve_r;
  assign sat_o   = sat_r;

endmodule

`default_nettype wire
